### hw/rtl/acm_pkg.sv
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and constants of the accumulator machine core: the request and
// response payloads, the opcode set and the status codes.
// ----------------------------------------------------------------------------
package acm_pkg;

   localparam int WORD_W  = 64;
   localparam int BYTE_W  = 8;
   localparam int DIGIT_W = 8;

   typedef struct packed {
      logic              cmd;
      logic [9:0]        address;
      logic [WORD_W-1:0] value;
      logic [BYTE_W-1:0] in_char;
   } req_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_END   = 2'd1,
      ST_RANGE = 2'd2,
      ST_BADOP = 2'd3
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] acc;
      logic [WORD_W-1:0] ix;
      logic [WORD_W-1:0] pc;
      logic              flag;
      logic              out_valid;
      logic [BYTE_W-1:0] out_char;
      logic              inspect;
      status_type        status;
   } rsp_type;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef enum logic [5:0] {
      OP_LDM   = 6'd0,  OP_LDD   = 6'd1,  OP_LDI   = 6'd2,  OP_LDX   = 6'd3,
      OP_LDR   = 6'd4,  OP_MOVIX = 6'd5,  OP_STO   = 6'd6,  OP_ADDI  = 6'd7,
      OP_ADDA  = 6'd8,  OP_SUBI  = 6'd9,  OP_SUBA  = 6'd10, OP_INCA  = 6'd11,
      OP_INCX  = 6'd12, OP_DECA  = 6'd13, OP_DECX  = 6'd14, OP_JMP   = 6'd15,
      OP_CMPA  = 6'd16, OP_CMPI  = 6'd17, OP_CMII  = 6'd18, OP_JPE   = 6'd19,
      OP_JPN   = 6'd20, OP_ANDI  = 6'd21, OP_ANDA  = 6'd22, OP_XORI  = 6'd23,
      OP_XORA  = 6'd24, OP_ORI   = 6'd25, OP_ORA   = 6'd26, OP_LSL   = 6'd27,
      OP_LSR   = 6'd28, OP_IN    = 6'd29, OP_OUT   = 6'd30, OP_END   = 6'd31,
      OP_ISP   = 6'd32
   } opcode_type;

   localparam int OP_W = 6;

endpackage

### hw/rtl/accumulator_machine_core.sv
// ----------------------------------------------------------------------------
// accumulator_machine_core
// 64-bit accumulator machine with one unified word memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: cmd 0 writes req_data.value to memory
//   word req_data.address, cmd 1 executes the two-word instruction at PC.
//   rsp_* returns one result per item: ACC, IX, PC, flag, the OUT byte, the
//   inspect request and a status code.
//   Items are handled one at a time. All memory traffic goes through the one
//   port of the word memory: a write item reduces its address and writes; a
//   step fetches opcode and argument, reduces a memory operand's address and
//   reads or stores it, and reduces and reads an indirect pointer as well. A
//   reduction is slower when MEM_WORDS is not a power of two and the address
//   is MEM_WORDS or more. A halted or out-of-range step skips the fetch.
//   After reset the memory is cleared one word per cycle; req_ready stays low
//   until the clear is done. Registers reset to zero and the machine runs.
//   The response sits in an output register; the next request is taken while
//   it waits, and that item completes once rsp_ready frees the register.
// ----------------------------------------------------------------------------
module accumulator_machine_core import acm_pkg::*; #(
   parameter int MEM_WORDS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW   = $clog2(MEM_WORDS);
   localparam int SH_W = $clog2(WORD_W);

   typedef enum logic [7:0] {
      S_CLEAR     = 8'b0000_0001,
      S_IDLE      = 8'b0000_0010,
      S_FETCH_OP  = 8'b0000_0100,
      S_FETCH_ARG = 8'b0000_1000,
      S_MOD       = 8'b0001_0000,
      S_READ      = 8'b0010_0000,
      S_EXEC      = 8'b0100_0000,
      S_RESP      = 8'b1000_0000
   } state_type;

   state_type         state_ff,  state_in;
   logic [AW-1:0]     clr_ff,    clr_in;
   req_type           req_ff,    req_in;
   logic [WORD_W-1:0] acc_ff,    acc_in;
   logic [WORD_W-1:0] ix_ff,     ix_in;
   logic [WORD_W-1:0] pc_ff,     pc_in;
   logic              flag_ff,   flag_in;
   logic              halted_ff, halted_in;
   logic [WORD_W-1:0] op_ff,     op_in;
   logic [WORD_W-1:0] arg_ff,    arg_in;
   logic [WORD_W-1:0] data_ff,   data_in;
   logic              second_ff, second_in;
   logic              ovalid_ff, ovalid_in;
   logic              insp_ff,   insp_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff,    rsp_in;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_addr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;

   logic              mod_start, mod_done;
   logic [WORD_W-1:0] mod_value;
   logic [AW-1:0]     mod_result;

   logic              accept;
   logic              pc_out;
   logic [AW-1:0]     pc_lo, pc_next_lo;
   logic              op_known;
   opcode_type        op_code;
   logic              needs_mem, is_indirect, arg_wide;
   logic              rsp_free;

   acm_word_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   acm_addr_mod #(.MEM_WORDS(MEM_WORDS)) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (mod_value),
      .done   (mod_done),
      .result (mod_result)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign pc_out     = (pc_ff >= WORD_W'(MEM_WORDS));
   assign pc_lo      = pc_ff[AW-1:0];
   assign pc_next_lo = (pc_lo == AW'(MEM_WORDS - 1)) ? '0 : pc_lo + AW'(1);
   assign op_known   = (op_ff[WORD_W-1:OP_W] == '0) && (op_ff[OP_W-1:0] <= OP_W'(OP_ISP));
   assign op_code    = opcode_type'(op_ff[OP_W-1:0]);
   assign arg_wide   = |arg_ff[WORD_W-1:SH_W];
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      needs_mem = 1'b0;
      if (op_known) begin
         case (op_code) inside
            OP_LDD, OP_LDI, OP_LDX, OP_STO, OP_ADDA, OP_SUBA, OP_CMPA, OP_CMII,
            OP_ANDA, OP_XORA, OP_ORA: needs_mem = 1'b1;
            default:                  needs_mem = 1'b0;
         endcase
      end
   end

   assign is_indirect = op_known && (op_code == OP_LDI || op_code == OP_CMII);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      req_in    = req_ff;
      acc_in    = acc_ff;
      ix_in     = ix_ff;
      pc_in     = pc_ff;
      flag_in   = flag_ff;
      halted_in = halted_ff;
      op_in     = op_ff;
      arg_in    = arg_ff;
      data_in   = data_ff;
      second_in = second_ff;
      ovalid_in = ovalid_ff;
      insp_in   = insp_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = '0;
      mem_wdata = '0;
      mod_start = 1'b0;
      mod_value = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               ovalid_in = 1'b0;
               insp_in   = 1'b0;
               status_in = ST_OK;
               if (req_data.cmd == CMD_WRITE) begin
                  mod_start = 1'b1;
                  mod_value = WORD_W'(req_data.address);
                  state_in  = S_MOD;
               end else if (halted_ff) begin
                  status_in = pc_out ? ST_RANGE : ST_END;
                  state_in  = S_RESP;
               end else if (pc_out) begin
                  halted_in = 1'b1;
                  status_in = ST_RANGE;
                  state_in  = S_RESP;
               end else begin
                  mem_re   = 1'b1;
                  mem_addr = pc_lo;
                  state_in = S_FETCH_OP;
               end
            end
         end
         S_FETCH_OP: begin
            op_in    = mem_rdata;
            mem_re   = 1'b1;
            mem_addr = pc_next_lo;
            state_in = S_FETCH_ARG;
         end
         S_FETCH_ARG: begin
            arg_in    = mem_rdata;
            pc_in     = pc_ff + WORD_W'(2);
            second_in = 1'b0;
            if (needs_mem) begin
               mod_start = 1'b1;
               mod_value = (op_code == OP_LDX) ? mem_rdata + ix_ff : mem_rdata;
               state_in  = S_MOD;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               mem_addr = mod_result;
               if (req_ff.cmd == CMD_WRITE) begin
                  mem_we    = 1'b1;
                  mem_wdata = req_ff.value;
                  state_in  = S_RESP;
               end else if (op_code == OP_STO) begin
                  mem_we    = 1'b1;
                  mem_wdata = acc_ff;
                  state_in  = S_RESP;
               end else begin
                  mem_re   = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            data_in = mem_rdata;
            if (is_indirect && !second_ff) begin
               // follow the pointer: reduce the fetched word and read again
               second_in = 1'b1;
               mod_start = 1'b1;
               mod_value = mem_rdata;
               state_in  = S_MOD;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (!op_known) begin
               status_in = ST_BADOP;
            end else begin
               unique case (op_code) inside
                  OP_LDM:   acc_in = arg_ff;
                  OP_LDD, OP_LDI, OP_LDX: acc_in = data_ff;
                  OP_LDR:   ix_in  = arg_ff;
                  OP_MOVIX: ix_in  = acc_ff;
                  OP_STO:   acc_in = acc_ff;
                  OP_ADDI:  acc_in = acc_ff + arg_ff;
                  OP_ADDA:  acc_in = acc_ff + data_ff;
                  OP_SUBI:  acc_in = acc_ff - arg_ff;
                  OP_SUBA:  acc_in = acc_ff - data_ff;
                  OP_INCA:  acc_in = acc_ff + WORD_W'(1);
                  OP_INCX:  ix_in  = ix_ff + WORD_W'(1);
                  OP_DECA:  acc_in = acc_ff - WORD_W'(1);
                  OP_DECX:  ix_in  = ix_ff - WORD_W'(1);
                  OP_JMP:   pc_in  = arg_ff;
                  OP_CMPA, OP_CMII: flag_in = (acc_ff == data_ff);
                  OP_CMPI:  flag_in = (acc_ff == arg_ff);
                  OP_JPE:   if (flag_ff) pc_in = arg_ff;
                  OP_JPN:   if (!flag_ff) pc_in = arg_ff;
                  OP_ANDI:  acc_in = acc_ff & arg_ff;
                  OP_ANDA:  acc_in = acc_ff & data_ff;
                  OP_XORI:  acc_in = acc_ff ^ arg_ff;
                  OP_XORA:  acc_in = acc_ff ^ data_ff;
                  OP_ORI:   acc_in = acc_ff | arg_ff;
                  OP_ORA:   acc_in = acc_ff | data_ff;
                  OP_LSL:   acc_in = arg_wide ? '0 : acc_ff << arg_ff[SH_W-1:0];
                  OP_LSR:   acc_in = arg_wide ? '0 : acc_ff >> arg_ff[SH_W-1:0];
                  OP_IN:    acc_in = {{(WORD_W - BYTE_W){req_ff.in_char[BYTE_W-1]}},
                                      req_ff.in_char};
                  OP_OUT:   ovalid_in = 1'b1;
                  OP_END: begin
                     halted_in = 1'b1;
                     status_in = ST_END;
                  end
                  OP_ISP:   insp_in = 1'b1;
                  default:  status_in = ST_BADOP;
               endcase
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.acc         = acc_ff;
               rsp_in.ix          = ix_ff;
               rsp_in.pc          = pc_ff;
               rsp_in.flag        = flag_ff;
               rsp_in.out_valid   = ovalid_ff;
               rsp_in.out_char    = ovalid_ff ? acc_ff[BYTE_W-1:0] : '0;
               rsp_in.inspect     = insp_ff;
               rsp_in.status      = status_ff;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         acc_ff       <= '0;
         ix_ff        <= '0;
         pc_ff        <= '0;
         flag_ff      <= 1'b0;
         halted_ff    <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         acc_ff       <= acc_in;
         ix_ff        <= ix_in;
         pc_ff        <= pc_in;
         flag_ff      <= flag_in;
         halted_ff    <= halted_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      op_ff     <= op_in;
      arg_ff    <= arg_in;
      data_ff   <= data_in;
      ovalid_ff <= ovalid_in;
      insp_ff   <= insp_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_mod_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_MOD)
      else $error("address reduction finished outside its wait state");

   a_port_single_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("memory port read and written in one cycle");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted machine resumed without reset");

   a_pc_update_slots: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == S_FETCH_ARG || state_ff == S_EXEC) |=> $stable(pc_ff))
      else $error("program counter changed outside fetch or execute");

endmodule

### hw/rtl/acm_word_mem.sv
// ----------------------------------------------------------------------------
// acm_word_mem
// Single-port word memory: one write or one read per cycle, registered read
// data that holds until the next read.
// ----------------------------------------------------------------------------
module acm_word_mem import acm_pkg::*; #(
   parameter int MEM_WORDS = 1024
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [$clog2(MEM_WORDS)-1:0] addr,
   input  logic [WORD_W-1:0]            wr_data,
   output logic [WORD_W-1:0]            rd_data
);

   logic [WORD_W-1:0] store_ff [MEM_WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/acm_addr_mod.sv
// ----------------------------------------------------------------------------
// acm_addr_mod
// Reduces a 64-bit word to a memory address modulo MEM_WORDS. Values already
// in range, and any value when MEM_WORDS is a power of two, are done in the
// next cycle; others take one digit of the word per cycle.
// ----------------------------------------------------------------------------
module acm_addr_mod import acm_pkg::*; #(
   parameter int MEM_WORDS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [WORD_W-1:0]            value,
   output logic                         done,
   output logic [$clog2(MEM_WORDS)-1:0] result
);

   localparam int  AW     = $clog2(MEM_WORDS);
   localparam int  RW     = AW + 1;
   localparam int  STEPS  = WORD_W / DIGIT_W;
   localparam int  CW     = $clog2(STEPS);
   localparam bit  POW2   = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
   localparam logic [RW-1:0] MOD_VAL = RW'(MEM_WORDS);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [CW-1:0]     cnt_ff,   cnt_in;
   logic [RW-1:0]     rem_ff,   rem_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [AW-1:0]     res_ff,   res_in;
   logic [RW-1:0]     rem_step;
   logic              fast;

   assign fast = POW2 || (value < WORD_W'(MEM_WORDS));

   // Restoring remainder, one digit of the word (MSB first) per cycle.
   always_comb begin
      rem_step = rem_ff;
      for (int i = 0; i < DIGIT_W; i++) begin
         rem_step = {rem_step[RW-2:0], shift_ff[WORD_W-1-i]};
         if (rem_step >= MOD_VAL) begin
            rem_step = rem_step - MOD_VAL;
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      res_in   = res_ff;
      if (start) begin
         if (fast) begin
            res_in  = value[AW-1:0];
            done_in = 1'b1;
         end else begin
            busy_in  = 1'b1;
            rem_in   = '0;
            shift_in = value;
            cnt_in   = '0;
         end
      end else if (busy_ff) begin
         rem_in   = rem_step;
         shift_in = shift_ff << DIGIT_W;
         cnt_in   = cnt_ff + CW'(1);
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = rem_step[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
